// ===== hdl/pfa_pkg.sv =====
// shared types and constants of the page frame allocator / replacer
// word formats, status and mode codes, register index, fifo control struct
// no dependencies
package pfa_pkg;

	localparam int PID_W    = 8;
	localparam int ADDR_W   = 19;
	localparam int RND_W    = 16;
	localparam int PAGE_W   = 12;
	localparam int FRAME_W  = 5;
	localparam int STATUS_W = 2;
	localparam int MODE_W   = 2;
	localparam int DATA_W   = 32;
	localparam int PADDR_W  = 3;

	// status codes
	localparam logic [STATUS_W-1:0] STATUS_FREE  = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_EVICT = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_OOM   = 2'd2;

	// replacement modes
	localparam logic [MODE_W-1:0] MODE_NONE   = 2'd0;
	localparam logic [MODE_W-1:0] MODE_FIFO   = 2'd1;
	localparam logic [MODE_W-1:0] MODE_RANDOM = 2'd2;

	// register index, taken from paddr[2]
	localparam logic REG_MODE_IDX = 1'b0;

	typedef struct packed {
		logic [PID_W-1:0]  process_id;
		logic [ADDR_W-1:0] fault_address;
		logic [RND_W-1:0]  random_value;
	} in_word_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [FRAME_W-1:0]  frame;
		logic                evicted_valid;
		logic [PID_W-1:0]    evicted_process;
		logic [PAGE_W-1:0]   evicted_page;
		logic [PAGE_W-1:0]   loaded_page;
	} out_word_t;

	typedef struct packed {
		logic [PID_W-1:0]  pid;
		logic [PAGE_W-1:0] page;
	} owner_entry_t;

	typedef struct packed {
		logic push;
		logic pop;
	} fifo_ctl_t;

endpackage

// ===== hdl/pfa_cdiv.sv =====
// two-stage divide by a constant: reciprocal multiply, then one correction step
// standalone, no package use
module pfa_cdiv #(
	parameter int NW  = 19,
	parameter int DIV = 128
) (
	input  logic          clk,
	input  logic [NW-1:0] n,
	output logic [NW-1:0] quot,
	output logic [NW-1:0] rem
);

	localparam int L  = $clog2(DIV);
	localparam int S  = NW + L;
	localparam int MW = NW + 1;
	localparam int PW = NW + MW;
	localparam int DW = $clog2(DIV + 1);
	localparam int XW = NW + DW;
	localparam logic [63:0]   M64  = (64'd1 << S) / 64'(DIV);
	localparam logic [MW-1:0] MUL  = MW'(M64);
	localparam logic [XW-1:0] DIVX = XW'(DIV);

	logic [PW-1:0] prod_s1;
	logic [NW-1:0] n_s1;
	logic [NW-1:0] q_est;
	logic [XW-1:0] back;
	logic [NW-1:0] r_est;
	logic [XW-1:0] r_wide;
	logic [XW-1:0] r_less;
	logic          corr;

	always_ff @(posedge clk) begin
		prod_s1 <= {{MW{1'b0}}, n} * {{NW{1'b0}}, MUL};
		n_s1    <= n;
	end

	// estimate is low by at most one
	always_comb begin
		q_est  = NW'(prod_s1 >> S);
		back   = {{DW{1'b0}}, q_est} * DIVX;
		r_est  = n_s1 - back[NW-1:0];
		r_wide = {{DW{1'b0}}, r_est};
		corr   = (r_wide >= DIVX);
		r_less = r_wide - DIVX;
	end

	always_ff @(posedge clk) begin
		quot <= corr ? q_est + NW'(1) : q_est;
		rem  <= corr ? r_less[NW-1:0] : r_est;
	end

endmodule

// ===== hdl/pfa_owner_mem.sv =====
// owner table: one entry per frame, owning process id and virtual page
// uses pfa_pkg for the entry type; registered read, one write port
module pfa_owner_mem #(
	parameter int DEPTH = 32,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic                  clk,
	input  logic                  wr_en,
	input  logic [AW-1:0]         wr_addr,
	input  pfa_pkg::owner_entry_t wr_data,
	input  logic [AW-1:0]         rd_addr,
	output pfa_pkg::owner_entry_t rd_data
);
	import pfa_pkg::*;

	owner_entry_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data <= mem[rd_addr];
	end

endmodule

// ===== hdl/pfa_fifo_ring.sv =====
// fifo ring of frame numbers for oldest-first eviction
// uses pfa_pkg for the control struct; ring memory with registered head read
module pfa_fifo_ring #(
	parameter int DEPTH = 32,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
	localparam int CW = $clog2(DEPTH + 1)
) (
	input  logic               clk,
	input  logic               arst_n,
	input  pfa_pkg::fifo_ctl_t ctl,
	input  logic [AW-1:0]      push_frame,
	output logic [AW-1:0]      head_frame,
	output logic [CW-1:0]      count
);
	import pfa_pkg::*;

	localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

	logic [AW-1:0] ring [DEPTH];
	logic [AW-1:0] head_q;
	logic [AW-1:0] tail_q;
	logic [CW-1:0] cnt_q;
	logic          push_ok;

	// append dropped when the ring is full and nothing leaves
	assign push_ok = ctl.push && (ctl.pop || (cnt_q != CW'(DEPTH)));
	assign count   = cnt_q;

	always_ff @(posedge clk) begin
		if (push_ok) begin
			ring[tail_q] <= push_frame;
		end
		head_frame <= ring[head_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			tail_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (ctl.pop) begin
				head_q <= (head_q == LAST) ? '0 : head_q + AW'(1);
			end
			if (push_ok) begin
				tail_q <= (tail_q == LAST) ? '0 : tail_q + AW'(1);
			end
			if (push_ok && !ctl.pop) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (!push_ok && ctl.pop) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

endmodule

// ===== hdl/page_frame_allocator_replacer_unit.sv =====
// top level of the page frame allocator with fifo / random replacement
// depends on pfa_pkg, pfa_cdiv, pfa_owner_mem, pfa_fifo_ring
//
//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+----------------------
//  in      | input     | in_valid / in_stall       | in_data  (in_word_t)
//  out     | output    | out_valid / out_stall     | out_data (out_word_t)
//  cfg     | input     | psel/penable/pwrite/pready| paddr, pwdata, prdata
//
// a fault word is taken only in idle, and no new word is taken until it has
// passed the constant-divide states div1 and div2, a decision state, an owner-ram
// read state and a write-back state that also loads the output register
// write-back waits while a finished word is still held by out_stall
// reset clears the mode, the allocation count and the fifo pointers; the
// owner table and ring contents are only read after they were written
module page_frame_allocator_replacer_unit #(
	parameter int NUM_FRAMES = 32,
	parameter int PAGE_BYTES = 128
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  pfa_pkg::in_word_t            in_data,
	output logic                         out_valid,
	input  logic                         out_stall,
	output pfa_pkg::out_word_t           out_data,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [pfa_pkg::PADDR_W-1:0]  paddr,
	input  logic [pfa_pkg::DATA_W-1:0]   pwdata,
	output logic [pfa_pkg::DATA_W-1:0]   prdata,
	output logic                         pready
);
	import pfa_pkg::*;

	localparam int FW = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1;
	localparam int CW = $clog2(NUM_FRAMES + 1);

	// sequencer states
	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_DIV1 = 3'd1;
	localparam logic [2:0] S_DIV2 = 3'd2;
	localparam logic [2:0] S_DEC  = 3'd3;
	localparam logic [2:0] S_RD   = 3'd4;
	localparam logic [2:0] S_WB   = 3'd5;

	logic [2:0]          state_q;
	logic [MODE_W-1:0]   mode_q;
	logic [PID_W-1:0]    pid_q;
	logic [ADDR_W-1:0]   addr_q;
	logic [RND_W-1:0]    rnd_q;
	logic [CW-1:0]       alloc_q;
	logic [STATUS_W-1:0] status_q;
	logic [FW-1:0]       frame_q;
	logic [PAGE_W-1:0]   page_q;
	out_word_t           out_q;
	logic                out_valid_q;

	logic [ADDR_W-1:0]   page_quot;
	logic [RND_W-1:0]    rnd_rem;
	logic [FW-1:0]       fifo_head;
	logic [CW-1:0]       fifo_cnt;
	fifo_ctl_t           fifo_ctl;
	owner_entry_t        owner_rd;
	owner_entry_t        owner_wr;
	logic                owner_we;

	logic                full;
	logic [STATUS_W-1:0] dec_status;
	logic [FW-1:0]       dec_frame;
	logic                wb_go;
	logic                cfg_wr;
	logic [FW+FRAME_W-1:0] frame_ext;
	out_word_t           out_next;

	// ------------------------------------------------------------------
	// configuration port
	// ------------------------------------------------------------------
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;
	assign prdata = (paddr[2] == REG_MODE_IDX) ? {{(DATA_W-MODE_W){1'b0}}, mode_q} : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_NONE;
		end else if (cfg_wr && (paddr[2] == REG_MODE_IDX)) begin
			mode_q <= pwdata[MODE_W-1:0];
		end
	end

	// ------------------------------------------------------------------
	// page number and random victim, both by constant divide
	// ------------------------------------------------------------------
	pfa_cdiv #(.NW(ADDR_W), .DIV(PAGE_BYTES)) u_page_div (
		.clk  (clk),
		.n    (addr_q),
		.quot (page_quot),
		.rem  ()
	);

	pfa_cdiv #(.NW(RND_W), .DIV(NUM_FRAMES)) u_rnd_div (
		.clk  (clk),
		.n    (rnd_q),
		.quot (),
		.rem  (rnd_rem)
	);

	// ------------------------------------------------------------------
	// state memories
	// ------------------------------------------------------------------
	pfa_fifo_ring #(.DEPTH(NUM_FRAMES)) u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (fifo_ctl),
		.push_frame (frame_q),
		.head_frame (fifo_head),
		.count      (fifo_cnt)
	);

	// owner ram always reads at the chosen frame, data is ready in write-back
	pfa_owner_mem #(.DEPTH(NUM_FRAMES)) u_owner (
		.clk     (clk),
		.wr_en   (owner_we),
		.wr_addr (frame_q),
		.wr_data (owner_wr),
		.rd_addr (frame_q),
		.rd_data (owner_rd)
	);

	// ------------------------------------------------------------------
	// victim decision
	// frames are never released, so the frames in use are always 0..alloc-1
	// and the lowest free frame is the allocation count
	// ------------------------------------------------------------------
	assign full = (alloc_q == CW'(NUM_FRAMES));

	always_comb begin
		dec_status = STATUS_OOM;
		dec_frame  = '0;
		if (!full) begin
			dec_status = STATUS_FREE;
			dec_frame  = alloc_q[FW-1:0];
		end else if ((mode_q == MODE_FIFO) && (fifo_cnt != '0)) begin
			dec_status = STATUS_EVICT;
			dec_frame  = fifo_head;
		end else if (mode_q == MODE_RANDOM) begin
			dec_status = STATUS_EVICT;
			dec_frame  = rnd_rem[FW-1:0];
		end
	end

	// ------------------------------------------------------------------
	// write-back: owner table, fifo ring, allocation count, output word
	// ------------------------------------------------------------------
	assign wb_go = (state_q == S_WB) && (!out_valid_q || !out_stall);

	assign owner_we = wb_go && (status_q != STATUS_OOM);
	assign owner_wr = '{pid: pid_q, page: page_q};

	// every assigned frame goes to the tail in fifo mode, pop only on fifo eviction
	assign fifo_ctl = '{
		push: wb_go && (status_q != STATUS_OOM) && (mode_q == MODE_FIFO),
		pop:  wb_go && (status_q == STATUS_EVICT) && (mode_q == MODE_FIFO)
	};

	assign frame_ext = (FW + FRAME_W)'(frame_q);

	always_comb begin
		out_next.status          = status_q;
		out_next.frame           = frame_ext[FRAME_W-1:0];
		out_next.evicted_valid   = (status_q == STATUS_EVICT);
		out_next.evicted_process = (status_q == STATUS_EVICT) ? owner_rd.pid : '0;
		out_next.evicted_page    = (status_q == STATUS_EVICT) ? owner_rd.page : '0;
		out_next.loaded_page     = (status_q != STATUS_OOM) ? page_q : '0;
	end

	// ------------------------------------------------------------------
	// sequencer
	// ------------------------------------------------------------------
	assign in_stall = (state_q != S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			alloc_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_DIV1;
					end
				end
				S_DIV1: state_q <= S_DIV2;
				S_DIV2: state_q <= S_DEC;
				S_DEC:  state_q <= S_RD;
				S_RD:   state_q <= S_WB;
				S_WB: begin
					if (wb_go) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase

			if (wb_go && (status_q == STATUS_FREE)) begin
				alloc_q <= alloc_q + CW'(1);
			end

			if (wb_go) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if ((state_q == S_IDLE) && in_valid) begin
			pid_q  <= in_data.process_id;
			addr_q <= in_data.fault_address;
			rnd_q  <= in_data.random_value;
		end
		if (state_q == S_DEC) begin
			status_q <= dec_status;
			frame_q  <= dec_frame;
			page_q   <= page_quot[PAGE_W-1:0];
		end
		if (wb_go) begin
			out_q <= out_next;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

`ifndef NO_ASSERTIONS
	// a new output word only appears out of write-back
	a_out_from_wb: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(state_q == S_WB))
		else $error("output word raised outside write-back");

	// out-of-memory words carry no frame, eviction or page
	a_oom_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (out_data.status == STATUS_OOM)) |->
		((out_data.frame == '0) && !out_data.evicted_valid &&
		 (out_data.evicted_page == '0) && (out_data.loaded_page == '0)))
		else $error("out-of-memory word with nonzero fields");

	// eviction flag follows the status
	a_evict_flag: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_data.evicted_valid == (out_data.status == STATUS_EVICT)))
		else $error("evicted_valid disagrees with status");

	// allocation count never passes the frame count
	a_alloc_bound: assert property (@(posedge clk) disable iff (!arst_n)
		alloc_q <= CW'(NUM_FRAMES))
		else $error("allocation count beyond frame count");
`endif

endmodule
